// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication, disabled while rst_n is low
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// clocked next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== sv/gtp_pkg.sv =====
// Package: widths, CORDIC arctangent table and shared types
`timescale 1ns / 1ps
package gtp_pkg;
    localparam int CordicStagesDef = 16;
    localparam int PW = 36;   // datapath width, 16.16 with headroom
    localparam int AW = 32;   // binary angle width

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0, REG_ORIGIN_Y = 3'd1, REG_ORIGIN_HEADING = 3'd2,
        REG_ANGLE_TOL = 3'd3, REG_POS_TOL = 3'd4, REG_TURN_RATE = 3'd5,
        REG_DRIVE_SPEED = 3'd6, REG_UNUSED = 3'd7
    } t_reg_idx;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0: v = 32'd536870912;
            5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;
            5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;
            5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;
            5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;
            5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // side data carried alongside the CORDIC pipes
    typedef struct packed {
        logic signed [15:0] tdx;
        logic signed [15:0] tdy;
        logic [15:0]        dh;
    } t_side;
endpackage

// ===== sv/go_to_point_heading_drive_step.sv =====
// Top level: go-to-point steering decision pipeline
`timescale 1ns / 1ps
// One steering decision per request. A request is taken in every cycle in
// which start is high (busy is always low) and its result is presented on
// the outputs with o_done high after it has passed through one input
// register, the rotation CORDIC chain, a gain-correction stage, the
// vectoring set-up stage, the vectoring CORDIC chain and two decision
// stages. Results cannot be stalled. Configuration writes should be made
// while no request is in flight.
module go_to_point_heading_drive_step
    import gtp_pkg::*;
#(
    parameter int CORDIC_STAGES = CordicStagesDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic signed [15:0] i_cur_x,
    input  logic signed [15:0] i_cur_y,
    input  logic [15:0]        i_cur_heading,
    input  logic signed [15:0] i_target_dx,
    input  logic signed [15:0] i_target_dy,
    output logic               o_done,
    output logic signed [10:0] o_forward_speed,
    output logic signed [14:0] o_turn_cmd,
    output logic               o_reached
);
    logic signed [15:0] r_ox, r_oy;
    logic [15:0] r_oh, r_pt;
    logic [14:0] r_at;
    logic [13:0] r_tr;
    logic [9:0]  r_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0; r_oy <= '0; r_oh <= '0;
            r_at <= 15'd546; r_pt <= 16'd50; r_tr <= 14'd79; r_ds <= 10'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X:       r_ox <= i_cfg_data;
                REG_ORIGIN_Y:       r_oy <= i_cfg_data;
                REG_ORIGIN_HEADING: r_oh <= i_cfg_data;
                REG_ANGLE_TOL:      r_at <= i_cfg_data[14:0];
                REG_POS_TOL:        r_pt <= i_cfg_data;
                REG_TURN_RATE:      r_tr <= i_cfg_data[13:0];
                REG_DRIVE_SPEED:    r_ds <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 0: displacement, quadrant fold of the rotation angle
    logic                 r0_vld;
    logic signed [PW-1:0] r0_x, r0_y;
    logic signed [AW:0]   r0_z;
    t_side                r0_side;
    logic signed [16:0]   dx, dy;
    logic [31:0]          negw;
    logic signed [AW:0]   zs;
    logic                 fold;

    always_comb begin
        dx   = 17'(i_cur_x) - 17'(r_ox);
        dy   = 17'(i_cur_y) - 17'(r_oy);
        negw = 32'd0 - {r_oh, 16'd0};
        zs   = $signed({negw[31], negw});
        fold = (zs > 33'sd1073741824) || (zs < -33'sd1073741824);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= start;
        end
        if (fold) begin
            r0_x <= -{{(PW-33){dx[16]}}, dx, 16'd0};
            r0_y <= -{{(PW-33){dy[16]}}, dy, 16'd0};
            r0_z <= zs[AW] ? zs + 33'sd2147483648 : zs - 33'sd2147483648;
        end else begin
            r0_x <= {{(PW-33){dx[16]}}, dx, 16'd0};
            r0_y <= {{(PW-33){dy[16]}}, dy, 16'd0};
            r0_z <= zs;
        end
        r0_side.tdx <= i_target_dx;
        r0_side.tdy <= i_target_dy;
        r0_side.dh  <= i_cur_heading - r_oh;
    end

    logic                 r1_vld;
    logic signed [PW-1:0] r1_x, r1_y;
    logic signed [AW:0]   r1_z;
    t_side                r1_side;

    gtp_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_rot (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(r0_vld), .i_x(r0_x), .i_y(r0_y), .i_z(r0_z), .i_side(r0_side),
        .o_vld(r1_vld), .o_x(r1_x), .o_y(r1_y), .o_z(r1_z), .o_side(r1_side)
    );

    // gain correction
    localparam int MW = PW + 17;
    logic                 r2_vld;
    logic signed [PW-1:0] r2_px, r2_py;
    t_side                r2_side;
    logic signed [MW-1:0] gx, gy;

    always_comb begin
        gx = (MW'(r1_x) * MW'(39797) + MW'(32768)) >>> 16;
        gy = (MW'(r1_y) * MW'(39797) + MW'(32768)) >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_px <= gx[PW-1:0];
        r2_py <= gy[PW-1:0];
        r2_side <= r1_side;
    end

    // stage 3: error vector, vectoring set-up
    logic                 r3_vld;
    logic signed [PW-1:0] r3_x, r3_y;
    logic signed [AW:0]   r3_z;
    t_side                r3_side;
    logic signed [PW-1:0] vx, vy;

    always_comb begin
        vx = {{(PW-32){r2_side.tdx[15]}}, r2_side.tdx, 16'd0} - r2_px;
        vy = {{(PW-32){r2_side.tdy[15]}}, r2_side.tdy, 16'd0} - r2_py;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        if (vx[PW-1]) begin
            r3_x <= -vx; r3_y <= -vy; r3_z <= 33'sh080000000;
        end else begin
            r3_x <= vx; r3_y <= vy; r3_z <= '0;
        end
        r3_side <= r2_side;
    end

    // carry raw error vector beside the vectoring chain
    logic signed [PW-1:0] vxd [CORDIC_STAGES+1];
    logic signed [PW-1:0] vyd [CORDIC_STAGES+1];
    assign vxd[0] = (r3_z[31]) ? -r3_x : r3_x;
    assign vyd[0] = (r3_z[31]) ? -r3_y : r3_y;
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_dl
        always_ff @(posedge i_clk) begin
            vxd[g+1] <= vxd[g];
            vyd[g+1] <= vyd[g];
        end
    end

    logic                 r4_vld;
    logic signed [PW-1:0] r4_x, r4_y;
    logic signed [AW:0]   r4_z;
    t_side                r4_side;

    gtp_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b1)) u_vec (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(r3_vld), .i_x(r3_x), .i_y(r3_y), .i_z(r3_z), .i_side(r3_side),
        .o_vld(r4_vld), .o_x(r4_x), .o_y(r4_y), .o_z(r4_z), .o_side(r4_side)
    );

    // stage 5: bearing, heading errors, reached flag
    logic               r5_vld, r5_reached;
    logic signed [15:0] r5_err, r5_rerr;
    logic signed [PW-1:0] ex, ey, ax, ay, tol;
    logic [31:0]        bz, b32;
    logic [15:0]        d2;

    always_comb begin
        ex  = vxd[CORDIC_STAGES];
        ey  = vyd[CORDIC_STAGES];
        ax  = ex[PW-1] ? -ex : ex;
        ay  = ey[PW-1] ? -ey : ey;
        tol = {{(PW-32){1'b0}}, r_pt, 16'd0};
        bz  = (ex == '0 && ey == '0) ? 32'd0 : r4_z[31:0];
        b32 = bz + 32'h8000;
        d2  = r4_side.dh - b32[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_err     <= d2;
        r5_rerr    <= d2 + 16'h8000;
        r5_reached <= (ax < tol) && (ay < tol);
    end

    // stage 6: choose direction and command
    logic [16:0] me, mr, mc;
    logic        rev;
    logic signed [15:0] ch;
    logic        r6_vld, r6_reached;
    logic signed [10:0] r6_fs;
    logic signed [14:0] r6_tc;

    always_comb begin
        me  = r5_err[15] ? -17'(r5_err) : 17'(r5_err);
        mr  = r5_rerr[15] ? -17'(r5_rerr) : 17'(r5_rerr);
        rev = !(me < mr);
        ch  = rev ? r5_rerr : r5_err;
        mc  = rev ? mr : me;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_reached <= r5_reached;
        if (mc > 17'(r_at)) begin
            r6_fs <= '0;
            r6_tc <= ch[15] ? $signed({1'b0, r_tr}) : -$signed({1'b0, r_tr});
        end else begin
            r6_tc <= '0;
            r6_fs <= rev ? -$signed({1'b0, r_ds}) : $signed({1'b0, r_ds});
        end
    end

    assign o_done = r6_vld;
    assign o_forward_speed = r6_fs;
    assign o_turn_cmd = r6_tc;
    assign o_reached = r6_reached;
endmodule

// ===== sv/gtp_cordic_stage.sv =====
// One registered CORDIC micro-rotation, rotation or vectoring mode
`timescale 1ns / 1ps
module gtp_cordic_stage
    import gtp_pkg::*;
#(
    parameter int SHIFT = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [PW-1:0] i_x,
    input  logic signed [PW-1:0] i_y,
    input  logic signed [AW:0]   i_z,
    input  t_side                i_side,
    output logic                 o_vld,
    output logic signed [PW-1:0] o_x,
    output logic signed [PW-1:0] o_y,
    output logic signed [AW:0]   o_z,
    output t_side                o_side
);
    logic signed [PW-1:0] n_x, n_y, xs, ys;
    logic signed [AW:0]   n_z, at;
    logic                 dir;
    logic                 r_vld;
    logic signed [PW-1:0] r_x, r_y;
    logic signed [AW:0]   r_z;
    t_side                r_side;

    always_comb begin
        xs  = i_x >>> SHIFT;
        ys  = i_y >>> SHIFT;
        at  = $signed({1'b0, atan_lut(5'(SHIFT))});
        dir = VECTORING ? !i_y[PW-1] : !i_z[AW];
        if (VECTORING ? dir : dir) begin
            if (VECTORING) begin
                n_x = i_x + ys; n_y = i_y - xs; n_z = i_z + at;
            end else begin
                n_x = i_x - ys; n_y = i_y + xs; n_z = i_z - at;
            end
        end else begin
            if (VECTORING) begin
                n_x = i_x - ys; n_y = i_y + xs; n_z = i_z - at;
            end else begin
                n_x = i_x + ys; n_y = i_y - xs; n_z = i_z + at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_side <= i_side;
    end

    assign o_vld = r_vld;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_side = r_side;
endmodule

// ===== sv/gtp_cordic.sv =====
// Chain of registered CORDIC stages
`timescale 1ns / 1ps
module gtp_cordic
    import gtp_pkg::*;
#(
    parameter int STAGES = CordicStagesDef,
    parameter bit VECTORING = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [PW-1:0] i_x,
    input  logic signed [PW-1:0] i_y,
    input  logic signed [AW:0]   i_z,
    input  t_side                i_side,
    output logic                 o_vld,
    output logic signed [PW-1:0] o_x,
    output logic signed [PW-1:0] o_y,
    output logic signed [AW:0]   o_z,
    output t_side                o_side
);
    logic                 v [STAGES+1];
    logic signed [PW-1:0] x [STAGES+1];
    logic signed [PW-1:0] y [STAGES+1];
    logic signed [AW:0]   z [STAGES+1];
    t_side                s [STAGES+1];

    assign v[0] = i_vld;
    assign x[0] = i_x;
    assign y[0] = i_y;
    assign z[0] = i_z;
    assign s[0] = i_side;

    for (genvar g = 0; g < STAGES; g++) begin : g_st
        gtp_cordic_stage #(.SHIFT(g), .VECTORING(VECTORING)) u_st (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(v[g]), .i_x(x[g]), .i_y(y[g]), .i_z(z[g]), .i_side(s[g]),
            .o_vld(v[g+1]), .o_x(x[g+1]), .o_y(y[g+1]), .o_z(z[g+1]), .o_side(s[g+1])
        );
    end

    assign o_vld = v[STAGES];
    assign o_x = x[STAGES];
    assign o_y = y[STAGES];
    assign o_z = z[STAGES];
    assign o_side = s[STAGES];
endmodule

// ===== sv/gtp_checker.sv =====
// Port-level checker for the steering pipeline, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gtp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic signed [10:0] o_forward_speed,
    input logic signed [14:0] o_turn_cmd
);
    `CHK_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `CHK_IMPL(a_turn_or_drive, i_clk, i_rst_n, o_done, o_forward_speed == '0 || o_turn_cmd == '0)
    `CHK_NEXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_done)
endmodule

bind go_to_point_heading_drive_step gtp_checker u_gtp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_forward_speed(o_forward_speed), .o_turn_cmd(o_turn_cmd)
);
